@@ src/bsws_pkg.sv @@
// Shared types, codes and defaults for the bounded stack with search.
package bsws_pkg;

    // Default number of words the stack holds
    localparam int BSWS_DEPTH = 16;

    // Command codes
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_LIST   = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;

    // Result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_EMPTY    = 2'd1;
    localparam logic [1:0] STS_FULL     = 2'd2;
    localparam logic [1:0] STS_NOTFOUND = 2'd3;

    // Input item
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand_value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_value;
        logic [4:0]         position;
        logic               is_empty;
        logic               last_result;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_OUT,
        S_LIST,
        S_FIND,
        S_NOT_FOUND,
        S_SCAN
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic       cap_in;
        logic       push_wr;
        logic       pop_dec;
        logic       rd_en;
        logic       idx_clr;
        logic       idx_inc;
        logic       hit_clr;
        logic       hit_upd;
        logic       emit;
        logic [1:0] status;
        logic       use_data;
        logic       use_pos;
        logic       last;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       is_empty;
        logic       is_full;
        logic       match;
        logic       idx_last;
        logic       idx_last_hit;
        logic       any_hit;
        logic       out_free;
    } t_dp_stat;

endpackage

@@ src/bounded_stack_with_search_top.sv @@
// Push, or any command on an empty stack, gives its result from the decode state; pop and
// peek read the top word, then give it; an unused code returns nothing and frees the input.
// List gives one result per word from the top down; search makes a match pass over every
// word, then gives each match down to the deepest, or one not-found result if none matches.
// Throughput: one item at a time; one word read per cycle while the output does not stall.
// Reset (synchronous, active low) empties the stack; stored words are not cleared.
module bounded_stack_with_search_top import bsws_pkg::*; #(
    parameter int STACK_DEPTH = BSWS_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    bsws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage and result path
    bsws_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Only one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while another is in work");

    // Never overwrite a result that is still held
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over a stalled result");

    // Full result comes from a non-empty stack and ends the command
    a_full_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == STS_FULL)
        |-> !o_out_item.is_empty && o_out_item.last_result)
        else $error("malformed full result");

    // Empty result reports an empty stack
    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == STS_EMPTY)
        |-> o_out_item.is_empty && o_out_item.last_result)
        else $error("malformed empty result");

endmodule

@@ src/bsws_dp.sv @@
// Datapath: word memory, count, walk index, hit tracking and result register.
module bsws_dp import bsws_pkg::*; #(
    parameter int STACK_DEPTH = BSWS_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic signed [31:0] r_mem [STACK_DEPTH];
    logic signed [31:0] r_rd_data;
    logic [2:0]         r_op;
    logic signed [31:0] r_val;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_last_hit;
    logic [CW-1:0]      idx_plus;
    logic [CW-1:0]      rd_pos;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               r_out_valid;
    t_out_item          r_out;

    // Walk index and addresses; the walk goes from the top down
    assign idx_plus = r_idx + CW'(1);
    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_plus;
        end else begin
            n_idx = r_idx;
        end
    end
    assign rd_pos  = r_count - CW'(1) - n_idx;
    assign rd_addr = rd_pos[AW-1:0];
    assign wr_addr = r_count[AW-1:0];

    // Next word count
    always_comb begin
        n_count = r_count;
        if (i_cmd.push_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_mem[wr_addr] <= r_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Capture the command item
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op  <= i_in_item.opcode;
            r_val <= i_in_item.operand_value;
        end
    end

    // Count, walk index and last hit position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_idx      <= '0;
            r_last_hit <= '0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.hit_clr) begin
                r_last_hit <= '0;
            end else if (i_cmd.hit_upd && o_stat.match) begin
                r_last_hit <= idx_plus;
            end
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status      <= i_cmd.status;
            r_out.data_value  <= i_cmd.use_data ? r_rd_data : 32'sd0;
            r_out.position    <= i_cmd.use_pos ? 5'(idx_plus) : 5'd0;
            r_out.is_empty    <= (n_count == '0);
            r_out.last_result <= i_cmd.last;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat.op           = r_op;
        o_stat.is_empty     = (r_count == '0);
        o_stat.is_full      = (r_count == CW'(STACK_DEPTH));
        o_stat.match        = (r_rd_data == r_val);
        o_stat.idx_last     = (idx_plus == r_count);
        o_stat.idx_last_hit = (idx_plus == r_last_hit);
        o_stat.any_hit      = o_stat.match || (r_last_hit != '0);
        o_stat.out_free     = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ src/bsws_ctrl.sv @@
// Controller: sequences each command through the datapath.
module bsws_ctrl import bsws_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.cap_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op) inside
                    OP_PUSH: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            if (i_stat.is_full) begin
                                o_cmd.status = STS_FULL;
                            end else begin
                                o_cmd.status  = STS_OK;
                                o_cmd.push_wr = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_POP, OP_PEEK, OP_LIST, OP_SEARCH: begin
                        if (i_stat.is_empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = STS_EMPTY;
                                o_cmd.last   = 1'b1;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            // Start a read of the top word
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.idx_clr = 1'b1;
                            if (i_stat.op == OP_POP) begin
                                o_cmd.pop_dec = 1'b1;
                                n_state       = S_READ_OUT;
                            end else if (i_stat.op == OP_PEEK) begin
                                n_state = S_READ_OUT;
                            end else if (i_stat.op == OP_LIST) begin
                                n_state = S_LIST;
                            end else begin
                                o_cmd.hit_clr = 1'b1;
                                n_state       = S_FIND;
                            end
                        end
                    end
                    default: begin
                        // Unused code: drop the item
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = STS_OK;
                    o_cmd.use_data = 1'b1;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = STS_OK;
                    o_cmd.use_data = 1'b1;
                    o_cmd.use_pos  = 1'b1;
                    o_cmd.last     = i_stat.idx_last;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                    end
                end
            end
            S_FIND: begin
                // First pass: locate the deepest match
                o_cmd.hit_upd = 1'b1;
                o_cmd.rd_en   = 1'b1;
                if (i_stat.idx_last) begin
                    if (i_stat.any_hit) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_SCAN;
                    end else begin
                        o_cmd.rd_en = 1'b0;
                        n_state     = S_NOT_FOUND;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_NOT_FOUND: begin
                if (i_stat.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = STS_NOTFOUND;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                // Second pass: emit every match, mark the deepest as last
                if (i_stat.match) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.status   = STS_OK;
                        o_cmd.use_data = 1'b1;
                        o_cmd.use_pos  = 1'b1;
                        o_cmd.last     = i_stat.idx_last_hit;
                        if (i_stat.idx_last_hit) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            o_cmd.rd_en   = 1'b1;
                        end
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
